>>> rtl/tssd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the scratchpad decoder.
// No dependencies; used by tssd_capture, tssd_convert and the top level.
package tssd_pkg;

    // Byte positions inside the nine-byte scratchpad
    localparam logic [3:0] BYTE_TEMP_LSB  = 4'd0;
    localparam logic [3:0] BYTE_TEMP_MSB  = 4'd1;
    localparam logic [3:0] BYTE_CONFIG    = 4'd4;
    localparam logic [3:0] BYTE_COUNT_REM = 4'd6;
    localparam logic [3:0] BYTE_COUNT_PER = 4'd7;
    localparam logic [3:0] BYTE_CRC       = 4'd8;
    localparam logic [3:0] COUNT_DONE     = 4'd9;

    // CRC-8, reflected form of x^8 + x^5 + x^4 + 1
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Short-format refinement constants
    localparam logic [7:0]  SHORT_REFINE_CPD = 8'h10;
    localparam logic [15:0] SHORT_MASK       = 16'hFFF0;
    localparam logic [15:0] SHORT_BIAS       = 16'd12;

    // Long-format resolution codes (config byte bits 6:5)
    localparam logic [1:0] RES_9BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_11BIT = 2'd2;
    localparam logic [1:0] RES_12BIT = 2'd3;

    // Captured scratchpad fields, handed from capture to conversion
    typedef struct packed {
        logic [7:0] crc_accum;
        logic [7:0] temp_low;
        logic [7:0] temp_high;
        logic [1:0] resolution_bits;
        logic [7:0] count_remain;
        logic [7:0] count_per_degree;
        logic       short_mode;
    } scratch_t;

    // One byte through the CRC, LSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] crc;
        logic       mix;
        crc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            mix = crc[0] ^ b[i];
            crc = {1'b0, crc[7:1]};
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

>>> rtl/tssd_capture.sv
// Scratchpad byte counter, running CRC-8 and field capture registers.
// Depends on tssd_pkg.
module tssd_capture
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid,        // item advances this cycle
    input  logic [7:0]          data_byte,
    input  logic                first_byte,
    input  logic                short_format,
    output logic                produce,      // current item is the CRC byte
    output tssd_pkg::scratch_t  scratch
);

    logic [3:0]         byte_count_reg;
    logic [3:0]         byte_count_next;
    tssd_pkg::scratch_t scratch_reg;
    tssd_pkg::scratch_t scratch_next;
    logic [3:0]         eff_count;
    logic [7:0]         eff_crc;

    // A first mark restarts count and CRC before the byte is taken
    assign eff_count = first_byte ? 4'd0 : byte_count_reg;
    assign eff_crc   = first_byte ? 8'd0 : scratch_reg.crc_accum;
    assign produce   = (eff_count == tssd_pkg::BYTE_CRC);
    assign scratch   = scratch_reg;

    // Next state of count, CRC and fields
    always_comb
    begin
        byte_count_next = byte_count_reg;
        scratch_next    = scratch_reg;
        if (valid && (eff_count < tssd_pkg::COUNT_DONE))
        begin
            if (eff_count < tssd_pkg::BYTE_CRC)
            begin
                scratch_next.crc_accum = tssd_pkg::crc8_feed(eff_crc, data_byte);
                unique case (eff_count)
                    tssd_pkg::BYTE_TEMP_LSB:
                    begin
                        scratch_next.temp_low   = data_byte;
                        scratch_next.short_mode = short_format;
                    end
                    tssd_pkg::BYTE_TEMP_MSB:  scratch_next.temp_high = data_byte;
                    tssd_pkg::BYTE_CONFIG:    scratch_next.resolution_bits = data_byte[6:5];
                    tssd_pkg::BYTE_COUNT_REM: scratch_next.count_remain = data_byte;
                    tssd_pkg::BYTE_COUNT_PER: scratch_next.count_per_degree = data_byte;
                    default:
                    begin
                    end
                endcase
                byte_count_next = eff_count + 4'd1;
            end
            else
            begin
                scratch_next.crc_accum = eff_crc;
                byte_count_next        = tssd_pkg::COUNT_DONE;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            scratch_reg    <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            scratch_reg    <= scratch_next;
        end
    end

endmodule

>>> rtl/tssd_convert.sv
// CRC check and conversion of captured fields to sixteenths of a degree.
// Depends on tssd_pkg.
module tssd_convert
(
    input  tssd_pkg::scratch_t  scratch,
    input  logic [7:0]          crc_byte,
    output logic [15:0]         temperature,
    output logic                crc_ok
);

    logic [15:0] raw;
    logic [15:0] shifted;
    logic [15:0] decoded;

    assign raw     = {scratch.temp_high, scratch.temp_low};
    assign shifted = {raw[12:0], 3'b000};
    assign crc_ok  = (scratch.crc_accum == crc_byte);

    // Short format: scale to 1/16 and, when count-per-degree is 16, refine with count-remain
    // Long format: clear the bits the resolution leaves undefined
    always_comb
    begin
        decoded = raw;
        if (scratch.short_mode)
        begin
            if (scratch.count_per_degree == tssd_pkg::SHORT_REFINE_CPD)
            begin
                decoded = (shifted & tssd_pkg::SHORT_MASK) + tssd_pkg::SHORT_BIAS
                          - {8'd0, scratch.count_remain};
            end
            else
            begin
                decoded = shifted;
            end
        end
        else
        begin
            unique case (scratch.resolution_bits)
                tssd_pkg::RES_9BIT:  decoded = {raw[15:3], 3'b000};
                tssd_pkg::RES_10BIT: decoded = {raw[15:2], 2'b00};
                tssd_pkg::RES_11BIT: decoded = {raw[15:1], 1'b0};
                tssd_pkg::RES_12BIT: decoded = raw;
                default:             decoded = raw;
            endcase
        end
    end

    // Temperature reads zero on a CRC mismatch
    assign temperature = crc_ok ? decoded : 16'd0;

endmodule

>>> rtl/temp_sensor_scratchpad_decode.sv
// Top level of the one-wire scratchpad temperature decoder.
// Depends on tssd_pkg, tssd_capture and tssd_convert.
//
// Feed the nine scratchpad bytes of one sensor, one byte per transfer, with
// tuser[0] set on byte 0 and tuser[1] giving the short-format family flag on
// that byte. The block keeps a CRC-8 over bytes 0 to 7 and, on byte 8, gives
// one result transfer: the temperature in signed sixteenths of a degree on
// tdata and the CRC verdict on tuser[0] (temperature reads 0 when the CRC is
// bad). Bytes past the ninth are dropped until the next first mark. An input
// register feeds a single pass of CRC update and field capture, and a result
// is registered in the output register as its byte leaves the input register,
// and is then offered on the master side. A new byte is accepted every cycle;
// the input side only stalls when a result is ready to move while the previous
// one is still waiting at the output.
module temp_sensor_scratchpad_decode
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] first_byte, [1] short_format
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] temperature (signed)
    output logic [0:0]  m_axis_tuser    // [0] crc_ok
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_first_reg;
    logic               in_short_reg;
    logic               out_valid_reg;
    logic [15:0]        out_temp_reg;
    logic               out_crc_ok_reg;
    logic               produce;
    logic               advance;
    tssd_pkg::scratch_t scratch;
    logic [15:0]        temperature;
    logic               crc_ok;

    // Item moves on unless it has a result and the output slot stays full
    assign advance       = in_valid_reg && (!produce || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser[0];
            in_short_reg <= s_axis_tuser[1];
        end
    end

    tssd_capture u_capture
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (advance),
        .data_byte    (in_byte_reg),
        .first_byte   (in_first_reg),
        .short_format (in_short_reg),
        .produce      (produce),
        .scratch      (scratch)
    );

    tssd_convert u_convert
    (
        .scratch     (scratch),
        .crc_byte    (in_byte_reg),
        .temperature (temperature),
        .crc_ok      (crc_ok)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_temp_reg   <= temperature;
            out_crc_ok_reg <= crc_ok;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_temp_reg;
    assign m_axis_tuser[0] = out_crc_ok_reg;

endmodule

>>> rtl/tssd_checker.sv
// Port-level checks for the scratchpad decoder, bound to its top level.
// Depends only on the top level's ports.
module tssd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A failed CRC reports zero temperature
    a_bad_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("nonzero temperature on bad CRC");

    // Input only stalls behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // A fresh result follows a matching earlier input transfer
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a matching input transfer");

endmodule

bind temp_sensor_scratchpad_decode tssd_checker u_tssd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
